FILE: rtl/pps_pkg.sv
// shared widths, limits and command codes of the priority scheduler
package pps_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned WAIT_W   = 16;
  localparam int unsigned TURN_W   = 17;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 48;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // kind of an incoming word, carried on tuser
  typedef enum logic {
    MODE_ADMIT = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  // update broadcast to every cell
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ADMIT = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

endpackage

FILE: rtl/pps_cell.sv
// one slot of the job table, with its stage of the selection chain
module pps_cell #(
  parameter int unsigned N      = 16,
  parameter int unsigned IDX    = 0,
  parameter type         cand_t = logic,
  parameter type         cmd_t  = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cand_t cand_i,
  output cand_t cand_o,
  input  cmd_t  cmd_i
);

  localparam int unsigned IDXW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CNTW = $clog2(N + 1);

  logic                          valid_q, valid_d;
  logic [pps_pkg::ID_W-1:0]      id_q;
  logic [pps_pkg::PRIO_W-1:0]    prio_q;
  logic [pps_pkg::BURST_W-1:0]   burst_q;
  logic [pps_pkg::BURST_W-1:0]   rem_q;
  logic [pps_pkg::WAIT_W-1:0]    wait_q;
  logic [IDXW-1:0]               age_q;
  cand_t                         cand_q, cand_d;
  logic                          is_sel;
  logic                          beats_in;

  assign is_sel = (cmd_i.sel == IDXW'(IDX));

  // own slot wins over the incoming best on lower priority, then lower age
  assign beats_in = valid_q && (!cand_i.found || (prio_q < cand_i.prio) ||
                    ((prio_q == cand_i.prio) && (age_q < cand_i.age)));

  always_comb begin
    cand_d      = cand_i;
    cand_d.used = cand_i.used + CNTW'(valid_q);
    if (!valid_q && !cand_i.free_found) begin
      cand_d.free_found = 1'b1;
      cand_d.free_idx   = IDXW'(IDX);
    end
    if (beats_in) begin
      cand_d.found     = 1'b1;
      cand_d.prio      = prio_q;
      cand_d.age       = age_q;
      cand_d.idx       = IDXW'(IDX);
      cand_d.id        = id_q;
      cand_d.burst     = burst_q;
      cand_d.remaining = rem_q;
      cand_d.wait_cnt  = wait_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    unique case (cmd_i.op)
      pps_pkg::CMD_ADMIT: begin
        if (is_sel) valid_d = 1'b1;
      end
      pps_pkg::CMD_TICK: begin
        if (is_sel && cmd_i.done) valid_d = 1'b0;
      end
      default: valid_d = valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pps_pkg::CMD_ADMIT && is_sel) begin
      id_q    <= cmd_i.id;
      prio_q  <= cmd_i.prio;
      burst_q <= cmd_i.burst;
      rem_q   <= cmd_i.burst;
      wait_q  <= '0;
      age_q   <= cmd_i.age;
    end else if (cmd_i.op == pps_pkg::CMD_TICK && valid_q) begin
      if (is_sel) begin
        rem_q <= rem_q - 1'b1;
      end else begin
        if (wait_q != pps_pkg::WAIT_MAX) wait_q <= wait_q + 1'b1;
        if (cmd_i.done && (age_q > cmd_i.gone_age)) age_q <= age_q - 1'b1;
      end
    end
  end

  assign cand_o = cand_q;

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// top level of the preemptive priority scheduler
//
// Keeps up to TABLE_SLOTS ready jobs, one per cell of a row of identical
// cells. A word with tuser low admits a job into the lowest free slot
// (rejected when the table is full or the burst is zero); a word with tuser
// high advances one tick: the valid job with the lowest priority number runs,
// ties going to the job admitted first, all other jobs accrue wait
// (saturating), and a job whose burst is used up leaves and reports its wait
// and turnaround. Every input word gives exactly one result word. The best
// job, the first free slot and the slot count travel down the row one cell
// per clock; a word passes from idle through the scan of the cell chain to
// the result state, where the update is applied and the result loaded, and
// back to idle, and only then is the next word accepted. A pending result
// in the output register does not block the next input word; it only holds
// the update step until it is taken.
module preemptive_priority_scheduler #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // job_id [7:0], job_priority [11:8], job_burst [27:12], zero [31:28]
  input  logic [pps_pkg::IN_W-1:0]   s_axis_tdata,
  // mode [0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // admit_ok [0], idle [1], run_id [9:2], finished [10],
  // finish_wait [26:11], finish_turnaround [43:27], zero [47:44]
  output logic [pps_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned N    = TABLE_SLOTS;
  localparam int unsigned IDXW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CNTW = $clog2(N + 1);

  // running best candidate, free slot and occupancy, handed cell to cell
  typedef struct packed {
    logic                        found;
    logic [pps_pkg::PRIO_W-1:0]  prio;
    logic [IDXW-1:0]             age;
    logic [IDXW-1:0]             idx;
    logic [pps_pkg::ID_W-1:0]    id;
    logic [pps_pkg::BURST_W-1:0] burst;
    logic [pps_pkg::BURST_W-1:0] remaining;
    logic [pps_pkg::WAIT_W-1:0]  wait_cnt;
    logic                        free_found;
    logic [IDXW-1:0]             free_idx;
    logic [CNTW-1:0]             used;
  } cand_t;

  // table update broadcast to all cells
  typedef struct packed {
    pps_pkg::cmd_e               op;
    logic [IDXW-1:0]             sel;
    logic [IDXW-1:0]             age;
    logic [pps_pkg::ID_W-1:0]    id;
    logic [pps_pkg::PRIO_W-1:0]  prio;
    logic [pps_pkg::BURST_W-1:0] burst;
    logic                        done;
    logic [IDXW-1:0]             gone_age;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [IDXW-1:0]              cnt_q, cnt_d;
  logic                         mode_q;
  logic [pps_pkg::ID_W-1:0]     in_id_q;
  logic [pps_pkg::PRIO_W-1:0]   in_prio_q;
  logic [pps_pkg::BURST_W-1:0]  in_burst_q;
  logic                         m_valid_q;
  logic [pps_pkg::OUT_W-1:0]    m_data_q;

  cand_t                        chain [N+1];
  cand_t                        best;
  cmd_t                         cmd;
  logic                         in_fire;
  logic                         out_free;
  logic                         commit;

  // result fields
  logic                         admit_ok;
  logic                         idle_tick;
  logic [pps_pkg::ID_W-1:0]     run_id;
  logic                         finished;
  logic [pps_pkg::WAIT_W-1:0]   fin_wait;
  logic [pps_pkg::TURN_W-1:0]   fin_turn;
  logic [pps_pkg::OUT_W-1:0]    res_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == ST_RESULT) && out_free;

  // chain of slot cells, the head sees an empty candidate
  assign chain[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    pps_cell #(
      .N      (N),
      .IDX    (g),
      .cand_t (cand_t),
      .cmd_t  (cmd_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cand_i (chain[g]),
      .cand_o (chain[g+1]),
      .cmd_i  (cmd)
    );
  end

  assign best = chain[N];

  // result and table update from the end of the chain
  always_comb begin
    cmd       = '0;
    cmd.op    = pps_pkg::CMD_NONE;
    admit_ok  = 1'b0;
    idle_tick = 1'b0;
    run_id    = '0;
    finished  = 1'b0;
    fin_wait  = '0;
    fin_turn  = '0;
    if (mode_q == pps_pkg::MODE_ADMIT) begin
      admit_ok  = (in_burst_q != '0) && best.free_found;
      cmd.sel   = best.free_idx;
      cmd.age   = best.used[IDXW-1:0];
      cmd.id    = in_id_q;
      cmd.prio  = in_prio_q;
      cmd.burst = in_burst_q;
      if (commit && admit_ok) cmd.op = pps_pkg::CMD_ADMIT;
    end else if (!best.found) begin
      idle_tick = 1'b1;
    end else begin
      run_id       = best.id;
      // a valid job always has at least one tick left
      finished     = (best.remaining == pps_pkg::BURST_W'(1));
      cmd.sel      = best.idx;
      cmd.done     = finished;
      cmd.gone_age = best.age;
      if (finished) begin
        fin_wait = best.wait_cnt;
        fin_turn = pps_pkg::TURN_W'(best.burst) + pps_pkg::TURN_W'(best.wait_cnt);
      end
      if (commit) cmd.op = pps_pkg::CMD_TICK;
    end
  end

  assign res_data = {4'b0, fin_turn, fin_wait, finished, run_id, idle_tick, admit_ok};

  // control sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // wait for the candidate to travel through every cell
        if (cnt_q == IDXW'(N - 1)) begin
          state_d = ST_RESULT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // captured input word and output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q     <= s_axis_tuser;
      in_id_q    <= s_axis_tdata[7:0];
      in_prio_q  <= s_axis_tdata[11:8];
      in_burst_q <= s_axis_tdata[27:12];
    end
    if (commit) m_data_q <= res_data;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
